/* rtl/core/dnsnfr_pkg.sv */
// Shared types and constants for the DNS name field reader.
package dnsnfr_pkg;

   localparam int unsigned SourceLenMaxDefault = 65535;

   localparam logic [7:0] PtrMask  = 8'hC0;
   localparam logic [7:0] DotChar  = 8'h2E;
   localparam logic [7:0] NulChar  = 8'h00;
   localparam logic [7:0] DestLenReset = 8'd255;

   localparam logic [2:0] StFull      = 3'd0;
   localparam logic [2:0] StPointer   = 3'd1;
   localparam logic [2:0] StMalformed = 3'd2;
   localparam logic [2:0] StOverflow  = 3'd3;
   localparam logic [2:0] StEmpty     = 3'd4;

   typedef struct packed {
      logic [7:0]  msg_byte;
      logic        start_req;
      logic [15:0] source_len;
   } req_type;

   typedef struct packed {
      logic [7:0]  name_char;
      logic        char_valid;
      logic        done_res;
      logic [2:0]  status;
      logic [15:0] consumed;
   } rsp_type;

endpackage

/* rtl/core/dns_name_field_reader_top.sv */
// DNS name field reader: decodes label-encoded names from a byte stream into dotted text.
//
// One message byte per request, one request per cycle sustained while rsp_ready
// is high. A request passes an input register, then the label/length decode
// updates the parse state and loads the result register. Requests that produce
// no character (first length byte, bytes outside a parse) are absorbed without a
// response. A done_res response closes the parse with its status and consumed
// count; on a failure status the characters already delivered are to be
// discarded. csr_wr_data sets the output buffer capacity (terminator included);
// the user must write it only while no parse is in flight, as the block itself
// does not enforce this.
module dns_name_field_reader_top #(
   parameter int unsigned SOURCE_LEN_MAX = dnsnfr_pkg::SourceLenMaxDefault
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  dnsnfr_pkg::req_type req_payload,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output dnsnfr_pkg::rsp_type rsp_payload,
   input  logic                csr_wr_en,
   input  logic [7:0]          csr_wr_data
);
   import dnsnfr_pkg::*;

   localparam logic [15:0] SrcMax = 16'(SOURCE_LEN_MAX);

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_LEN,
      PH_LABEL
   } phase_type;

   logic        in_valid_ff;
   req_type     in_req_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;
   logic [7:0]  dest_len_ff;
   phase_type   phase_ff, phase_in;
   logic [15:0] byte_index_ff, byte_index_in;
   logic [7:0]  name_length_ff, name_length_in;
   logic [7:0]  label_left_ff, label_left_in;
   logic [15:0] source_total_ff, source_total_in;

   logic        advance;
   logic        emit;

   logic [7:0]  b;
   phase_type   ph;
   logic [15:0] bi;
   logic [7:0]  nl;
   logic [15:0] src;
   logic [16:0] bi_inc;
   logic [16:0] label_end;
   logic [15:0] bi_lab;
   logic [7:0]  ll_dec;
   logic        sep;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      b   = in_req_ff.msg_byte;
      ph  = in_req_ff.start_req ? PH_IDLE : phase_ff;
      bi  = in_req_ff.start_req ? 16'd0 : byte_index_ff;
      nl  = in_req_ff.start_req ? 8'd0 : name_length_ff;
      src = source_total_ff;
      if (in_req_ff.start_req) begin
         src = (in_req_ff.source_len > SrcMax) ? SrcMax : in_req_ff.source_len;
      end
      sep       = nl != 8'd0;
      bi_inc    = {1'b0, bi} + 17'd1;
      label_end = bi_inc + {9'd0, b};
      bi_lab    = bi + 16'd1;
      ll_dec    = (label_left_ff != 8'd0) ? label_left_ff - 8'd1 : 8'd0;

      phase_in        = ph;
      byte_index_in   = bi;
      name_length_in  = nl;
      label_left_in   = in_req_ff.start_req ? 8'd0 : label_left_ff;
      source_total_in = src;
      emit            = 1'b0;
      rsp_in          = '0;

      if (in_req_ff.start_req && src == 16'd0) begin
         emit = 1'b1;
         rsp_in.done_res = 1'b1;
         rsp_in.status   = StEmpty;
      end else if (in_req_ff.start_req && (b & PtrMask) == PtrMask) begin
         emit = 1'b1;
         rsp_in.done_res = 1'b1;
         if (src > 16'd2) begin
            rsp_in.status   = StPointer;
            rsp_in.consumed = 16'd2;
         end else begin
            rsp_in.status = StMalformed;
         end
      end else if (in_req_ff.start_req || ph == PH_LEN) begin
         if (b == NulChar) begin
            emit = 1'b1;
            phase_in = PH_IDLE;
            rsp_in.done_res = 1'b1;
            if (bi == 16'd0) begin
               rsp_in.status = StMalformed;
            end else if (nl >= dest_len_ff) begin
               rsp_in.status = StOverflow;
            end else begin
               rsp_in.char_valid = 1'b1;
               rsp_in.status     = StFull;
               rsp_in.consumed   = bi_inc[15:0];
            end
         end else if (sep && nl >= dest_len_ff) begin
            emit = 1'b1;
            phase_in = PH_IDLE;
            rsp_in.done_res = 1'b1;
            rsp_in.status   = StOverflow;
         end else begin
            byte_index_in = bi_inc[15:0];
            if (label_end > {1'b0, src}) begin
               emit = 1'b1;
               phase_in = PH_IDLE;
               rsp_in.done_res = 1'b1;
               rsp_in.status   = StMalformed;
            end else begin
               label_left_in = b;
               phase_in      = PH_LABEL;
               if (sep) begin
                  name_length_in    = nl + 8'd1;
                  emit              = 1'b1;
                  rsp_in.name_char  = DotChar;
                  rsp_in.char_valid = 1'b1;
               end
            end
         end
      end else if (ph == PH_LABEL) begin
         emit = 1'b1;
         if (nl >= dest_len_ff) begin
            phase_in = PH_IDLE;
            rsp_in.done_res = 1'b1;
            rsp_in.status   = StOverflow;
         end else begin
            name_length_in = nl + 8'd1;
            byte_index_in  = bi_lab;
            label_left_in  = ll_dec;
            if (ll_dec == 8'd0 && bi_lab >= src) begin
               phase_in = PH_IDLE;
               rsp_in.done_res = 1'b1;
               rsp_in.status   = StMalformed;
            end else begin
               if (ll_dec == 8'd0) begin
                  phase_in = PH_LEN;
               end
               rsp_in.name_char  = b;
               rsp_in.char_valid = 1'b1;
            end
         end
      end

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (advance && emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         dest_len_ff     <= DestLenReset;
         phase_ff        <= PH_IDLE;
         byte_index_ff   <= '0;
         name_length_ff  <= '0;
         label_left_ff   <= '0;
         source_total_ff <= '0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            dest_len_ff <= csr_wr_data;
         end
         if (advance) begin
            phase_ff        <= phase_in;
            byte_index_ff   <= byte_index_in;
            name_length_ff  <= name_length_in;
            label_left_ff   <= label_left_in;
            source_total_ff <= source_total_in;
         end
      end
      if (req_ready && req_valid) begin
         in_req_ff <= req_payload;
      end
      if (advance && emit) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

/* bench/dns_name_field_reader_top_tb.sv */
// Testbench for dns_name_field_reader_top: directed table, then predictor-checked random fields.
`timescale 1ns / 100ps

module dns_name_field_reader_top_tb;
   import dnsnfr_pkg::*;

   typedef enum logic [1:0] {ParseIdle, ParseLength, ParseLabel} parse_phase_type;

   typedef struct packed {
      req_type    req;
      logic       typed;
      rsp_type    rsp;
   } stim_row_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_payload;
   logic    csr_wr_en;
   logic [7:0] csr_wr_data;

   // typed result held alongside the payload of a table row
   logic    typed_row;
   rsp_type typed_rsp;

   rsp_type pending_name_rsps[$];
   int      fail_count = 0;
   int      sent_reqs = 0;
   int      burst_left = 0;

   // predictor state
   logic [7:0]      dest_cap = DestLenReset;
   parse_phase_type parse_phase = ParseIdle;
   int unsigned     byte_idx = 0;
   int unsigned     name_len = 0;
   int unsigned     label_left = 0;
   int unsigned     src_total = 0;

   stim_row_type dir_table [21] = '{
      '{'{8'h41, 1'b1, 16'h0000}, 1'b1, '{NulChar, 1'b0, 1'b1, StEmpty, 16'd0}},
      '{'{8'h55, 1'b0, 16'hFFFF}, 1'b0, '0},
      '{'{8'hC0, 1'b1, 16'd5}, 1'b1, '{NulChar, 1'b0, 1'b1, StPointer, 16'd2}},
      '{'{8'hFF, 1'b1, 16'd2}, 1'b1, '{NulChar, 1'b0, 1'b1, StMalformed, 16'd0}},
      '{'{8'hC3, 1'b1, 16'd3}, 1'b1, '{NulChar, 1'b0, 1'b1, StPointer, 16'd2}},
      '{'{8'h00, 1'b1, 16'd10}, 1'b1, '{NulChar, 1'b0, 1'b1, StMalformed, 16'd0}},
      '{'{8'h40, 1'b1, 16'd10}, 1'b1, '{NulChar, 1'b0, 1'b1, StMalformed, 16'd0}},
      '{'{8'h80, 1'b1, 16'hFFFF}, 1'b0, '0},
      '{'{8'hFF, 1'b0, 16'h0000}, 1'b0, '0},
      '{'{8'h00, 1'b0, 16'hFFFF}, 1'b0, '0},
      '{'{8'h03, 1'b1, 16'hFFFF}, 1'b0, '0},
      '{'{8'h61, 1'b0, 16'h0000}, 1'b0, '0},
      '{'{8'h62, 1'b0, 16'h0000}, 1'b0, '0},
      '{'{8'h63, 1'b0, 16'h0000}, 1'b0, '0},
      '{'{8'h02, 1'b0, 16'h0000}, 1'b0, '0},
      '{'{8'h78, 1'b0, 16'h0000}, 1'b0, '0},
      '{'{8'h79, 1'b0, 16'h0000}, 1'b0, '0},
      '{'{8'h00, 1'b0, 16'h0000}, 1'b0, '0},
      '{'{8'h02, 1'b1, 16'd3}, 1'b0, '0},
      '{'{8'h70, 1'b0, 16'h0000}, 1'b0, '0},
      '{'{8'h71, 1'b0, 16'h0000}, 1'b0, '0}
   };

   dns_name_field_reader_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #8ms;
      $display("** dns_name_field_reader_top: FAILED **");
      $finish;
   end

   function automatic rsp_type close_parse(logic [2:0] st, logic [15:0] used);
      parse_phase = ParseIdle;
      return '{NulChar, 1'b0, 1'b1, st, used};
   endfunction

   function automatic bit decode_length_byte(input logic [7:0] b, output rsp_type o);
      bit sep;
      sep = name_len > 0;
      o = '0;
      if (b == 8'h00) begin
         if (byte_idx == 0)
            o = close_parse(StMalformed, 16'd0);
         else if (name_len >= dest_cap)
            o = close_parse(StOverflow, 16'd0);
         else begin
            parse_phase = ParseIdle;
            o = '{NulChar, 1'b1, 1'b1, StFull, 16'(byte_idx + 1)};
         end
         return 1'b1;
      end
      if (sep && name_len >= dest_cap) begin
         o = close_parse(StOverflow, 16'd0);
         return 1'b1;
      end
      byte_idx++;
      if (byte_idx + b > src_total) begin
         o = close_parse(StMalformed, 16'd0);
         return 1'b1;
      end
      label_left = b;
      parse_phase = ParseLabel;
      if (sep) begin
         name_len++;
         o = '{DotChar, 1'b1, 1'b0, StFull, 16'd0};
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic bit decode_name_byte(input req_type r, output rsp_type o);
      o = '0;
      if (r.start_req) begin
         src_total = (r.source_len > SourceLenMaxDefault) ? SourceLenMaxDefault : r.source_len;
         byte_idx = 0;
         name_len = 0;
         label_left = 0;
         parse_phase = ParseIdle;
         if (src_total == 0) begin
            o = close_parse(StEmpty, 16'd0);
            return 1'b1;
         end
         if ((r.msg_byte & PtrMask) == PtrMask) begin
            o = (src_total > 2) ? close_parse(StPointer, 16'd2)
                                : close_parse(StMalformed, 16'd0);
            return 1'b1;
         end
         return decode_length_byte(r.msg_byte, o);
      end
      case (parse_phase)
         ParseLength: begin
            return decode_length_byte(r.msg_byte, o);
         end
         ParseLabel: begin
            if (name_len >= dest_cap) begin
               o = close_parse(StOverflow, 16'd0);
               return 1'b1;
            end
            name_len++;
            byte_idx++;
            if (label_left > 0)
               label_left--;
            if (label_left == 0) begin
               if (byte_idx >= src_total) begin
                  o = close_parse(StMalformed, 16'd0);
                  return 1'b1;
               end
               parse_phase = ParseLength;
            end
            o = '{r.msg_byte, 1'b1, 1'b0, StFull, 16'd0};
            return 1'b1;
         end
         default: begin
            return 1'b0;
         end
      endcase
   endfunction

   function automatic void check_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin : name_monitor
      rsp_type pred;
      rsp_type want;
      bit      has;
      if (!reset) begin
         if (req_valid && req_ready) begin
            sent_reqs++;
            has = decode_name_byte(req_payload, pred);
            if (typed_row)
               pending_name_rsps.push_back(typed_rsp);
            else if (has)
               pending_name_rsps.push_back(pred);
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_name_rsps.size() == 0) begin
               $error("response with nothing pending: %h", rsp_payload);
               fail_count++;
            end else begin
               want = pending_name_rsps.pop_front();
               check_field("name_char", want.name_char, rsp_payload.name_char);
               check_field("char_valid", want.char_valid, rsp_payload.char_valid);
               check_field("done_res", want.done_res, rsp_payload.done_res);
               check_field("status", want.status, rsp_payload.status);
               check_field("consumed", want.consumed, rsp_payload.consumed);
            end
         end
      end
   end

   // mostly short gaps, a few long
   function automatic int gap_len();
      return ($urandom_range(0, 19) < 17) ? $urandom_range(1, 3) : $urandom_range(8, 30);
   endfunction

   initial begin
      rsp_ready = 1'b0;
      @(negedge clock);
      forever begin
         rsp_ready = 1'b1;
         repeat (($urandom_range(0, 3) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 5))
            @(negedge clock);
         rsp_ready = 1'b0;
         repeat (gap_len()) @(negedge clock);
      end
   end

   // called at a falling edge; returns at the falling edge after the request is taken
   task automatic push_req(input req_type r, input logic typed, input rsp_type t);
      if (burst_left > 0)
         burst_left--;
      else if ($urandom_range(0, 24) == 0)
         burst_left = $urandom_range(30, 120);
      else if ($urandom_range(0, 1) == 1) begin
         req_valid = 1'b0;
         repeat (gap_len()) @(negedge clock);
      end
      req_valid = 1'b1;
      req_payload = r;
      typed_row = typed;
      typed_rsp = t;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_dest_capacity(input logic [7:0] cap);
      if (parse_phase != ParseIdle)
         push_req('{8'h00, 1'b1, 16'd0}, 1'b0, '0);
      req_valid = 1'b0;
      while (pending_name_rsps.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_wr_en = 1'b1;
      csr_wr_data = cap;
      dest_cap = cap;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   // mode 0: well formed, 1: source length up to the field size, 2: cut off by the next start
   task automatic send_name(input int mode);
      logic [7:0]  field[$];
      int          labels;
      int          len;
      int          sent;
      logic [15:0] src;
      req_type     r;
      labels = ($urandom_range(0, 29) == 0) ? 0 : $urandom_range(1, 6);
      repeat (labels) begin
         case ($urandom_range(0, 39))
            0: len = $urandom_range(64, 255);
            1, 2, 3, 4: len = $urandom_range(20, 63);
            default: len = $urandom_range(1, 10);
         endcase
         field.push_back(8'(len));
         repeat (len) field.push_back(8'($urandom_range(0, 255)));
      end
      field.push_back(8'h00);
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: src = 16'(field.size() + $urandom_range(0, 4));
         6, 7: src = 16'(field.size());
         8: src = 16'($urandom_range(0, 65535));
         default: src = 16'hFFFF;
      endcase
      if (mode == 1)
         src = 16'($urandom_range(1, field.size()));
      sent = (mode == 2 && field.size() > 1) ? $urandom_range(1, field.size() - 1)
                                             : field.size();
      for (int i = 0; i < sent; i++) begin
         r.msg_byte = field[i];
         r.start_req = (i == 0);
         r.source_len = (i == 0) ? src : 16'($urandom_range(0, 65535));
         push_req(r, 1'b0, '0);
      end
   endtask

   task automatic send_random_field();
      int      pick;
      req_type r;
      pick = $urandom_range(0, 99);
      if (pick < 60)
         send_name(0);
      else if (pick < 80)
         send_name($urandom_range(1, 2));
      else if (pick < 90) begin
         r.msg_byte = {2'b11, 6'($urandom_range(0, 63))};
         r.start_req = 1'b1;
         r.source_len = ($urandom_range(0, 1) == 1) ? 16'($urandom_range(0, 3))
                                                    : 16'($urandom_range(0, 65535));
         push_req(r, 1'b0, '0);
         repeat ($urandom_range(0, 2)) begin
            r.msg_byte = 8'($urandom_range(0, 255));
            r.start_req = 1'b0;
            r.source_len = 16'($urandom_range(0, 65535));
            push_req(r, 1'b0, '0);
         end
      end else begin
         repeat ($urandom_range(1, 6)) begin
            r.msg_byte = 8'($urandom_range(0, 255));
            r.start_req = ($urandom_range(0, 3) == 0);
            r.source_len = 16'($urandom_range(0, 65535));
            push_req(r, 1'b0, '0);
         end
      end
   endtask

   initial begin
      logic [7:0] caps [8];
      int         target;
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      typed_row = 1'b0;
      typed_rsp = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      repeat (4) @(negedge clock);
      reset = 1'b0;

      foreach (dir_table[i])
         push_req(dir_table[i].req, dir_table[i].typed, dir_table[i].rsp);

      caps[0] = 8'd0;
      caps[1] = 8'd1;
      caps[2] = 8'd255;
      caps[3] = 8'd2;
      caps[4] = 8'($urandom_range(3, 40));
      caps[5] = 8'd254;
      caps[6] = 8'($urandom_range(0, 255));
      caps[7] = 8'd128;
      foreach (caps[p]) begin
         write_dest_capacity(caps[p]);
         // the last field of each round may run past the target
         target = sent_reqs + 50;
         while (sent_reqs < target)
            send_random_field();
      end

      req_valid = 1'b0;
      while (pending_name_rsps.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (fail_count == 0 && pending_name_rsps.size() == 0)
         $display("** dns_name_field_reader_top: PASSED **");
      else
         $display("** dns_name_field_reader_top: FAILED **");
      $finish;
   end

endmodule

/* sim.f */
rtl/core/dnsnfr_pkg.sv
rtl/core/dns_name_field_reader_top.sv
bench/dns_name_field_reader_top_tb.sv
